FILE: rtl/pidsf_pkg.sv
package pidsf_pkg;

    localparam int DATA_W     = 32;
    localparam int OUT_W      = 27;
    localparam int FRAC_BITS  = 16;
    localparam int DIST_COUNT = 2;
    localparam int CFG_IDX_W  = 4;
    localparam int MUL_W      = DATA_W + 1;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int ACC_W      = 64;

    // Second disturbance term takes part only when configured for it
    localparam bit DIST_USE_1 = (DIST_COUNT >= 2);

    // Low-pass coefficient: round(0.01 * 2^FRAC_BITS) and its complement
    localparam longint ALPHA_VAL = ((64'sd1 <<< FRAC_BITS) + 64'sd50) / 64'sd100;
    localparam logic signed [MUL_W-1:0] ALPHA_Q     = MUL_W'(ALPHA_VAL);
    localparam logic signed [MUL_W-1:0] ONE_M_ALPHA = MUL_W'((64'sd1 <<< FRAC_BITS) - ALPHA_VAL);
    localparam logic signed [MUL_W-1:0] VEL_GAIN_NEG = -MUL_W'(200);

    localparam logic signed [ACC_W-1:0] FORCE_LIMIT = ACC_W'(64'sd1000 <<< FRAC_BITS);
    localparam logic signed [ACC_W-1:0] SAT_MAX     = ACC_W'(64'sd2147483647);
    localparam logic signed [ACC_W-1:0] SAT_MIN     = ACC_W'(-64'sd2147483648);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LAW_MODE      = 4'd0,
        REG_GAIN_PROP     = 4'd1,
        REG_GAIN_INTEG    = 4'd2,
        REG_GAIN_DERIV    = 4'd3,
        REG_STEP_TIME     = 4'd4,
        REG_INV_STEP_TIME = 4'd5,
        REG_DIST_WEIGHT_0 = 4'd6,
        REG_DIST_WEIGHT_1 = 4'd7
    } t_reg_idx;

    typedef struct packed {
        logic                     law_mode;
        logic signed [DATA_W-1:0] gain_prop;
        logic signed [DATA_W-1:0] gain_integ;
        logic signed [DATA_W-1:0] gain_deriv;
        logic        [DATA_W-1:0] step_time;
        logic        [DATA_W-2:0] inv_step_time;
        logic signed [DATA_W-1:0] dist_weight_0;
        logic signed [DATA_W-1:0] dist_weight_1;
    } t_cfg;

    localparam logic [DATA_W-1:0] STEP_TIME_RST     = 32'd4294967;
    localparam logic [DATA_W-2:0] INV_STEP_TIME_RST = 31'd65536000;

    // Clamp a wide signed value to the signed 32-bit range
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] x);
        logic signed [DATA_W-1:0] r;
        if (x > SAT_MAX) begin
            r = DATA_W'(SAT_MAX);
        end else if (x < SAT_MIN) begin
            r = DATA_W'(SAT_MIN);
        end else begin
            r = DATA_W'(x);
        end
        return r;
    endfunction

endpackage

FILE: rtl/pidsf_if.sv
interface pidsf_item_if;
    logic                                valid;
    logic                                ready;
    logic signed [pidsf_pkg::DATA_W-1:0] body_position;
    logic signed [pidsf_pkg::DATA_W-1:0] body_velocity;
    logic signed [pidsf_pkg::DATA_W-1:0] road_input_0;
    logic signed [pidsf_pkg::DATA_W-1:0] road_input_1;

    modport source (output valid, body_position, body_velocity, road_input_0, road_input_1,
                    input ready);
    modport sink   (input valid, body_position, body_velocity, road_input_0, road_input_1,
                    output ready);
endinterface

interface pidsf_result_if;
    logic                               valid;
    logic                               ready;
    logic signed [pidsf_pkg::OUT_W-1:0] actuator_force;
    logic                               force_clipped;

    modport source (output valid, actuator_force, force_clipped, input ready);
    modport sink   (input valid, actuator_force, force_clipped, output ready);
endinterface

interface pidsf_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [pidsf_pkg::CFG_IDX_W-1:0]   index;
    logic [pidsf_pkg::DATA_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/pid_suspension_force.sv
// Active-suspension PID force controller.
// i_item carries one sample (body position, body velocity, two road inputs,
// all signed Q16.16); o_result returns one clipped actuator force per sample
// plus a flag that is set when the +-1000 N limit was applied. i_cfg writes
// the mode, gains, sample period, its reciprocal and disturbance weights;
// write it only while no sample is in flight.
// All products go through one registered 33x33 signed multiplier under a
// small sequencer, so the block takes one sample at a time:
//   position mode: road inputs weighted and added, then the common tail of
//   integral, derivative, gains and clip; jerk mode: second difference,
//   scaled twice, low-passed (zero while history fills), then the tail.
// i_item.ready is high only while the sequencer idles. A finished result
// sits in an output register, so the next sample is taken while it waits;
// if the receiver still stalls when the next force is ready, the sequencer
// holds in its last step until the register frees up.
// Reset (synchronous, active low) clears the integral, last error, velocity
// history and history count, drops any pending result and restores the
// register defaults (1 ms period, 1000/s reciprocal, zero gains).
module pid_suspension_force (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pidsf_item_if.sink    i_item,
    pidsf_result_if.source o_result,
    pidsf_cfg_if.sink     i_cfg
);
    import pidsf_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE,
        S_P_W0, S_P_W1, S_P_SUM,
        S_J_D2, S_J_M1, S_J_S1, S_J_M2, S_J_S2, S_J_A0, S_J_A1, S_J_ERR,
        S_C_INT, S_C_DER, S_C_GP, S_C_GI, S_C_GD, S_C_VEL, S_C_SUM, S_C_CLIP
    } t_state;

    localparam logic signed [OUT_W-1:0] LIM_OUT = OUT_W'(FORCE_LIMIT);

    t_cfg cfg;

    // Sequencer and model state
    t_state                   r_state,     n_state;
    logic                     r_out_valid, n_out_valid;
    logic signed [OUT_W-1:0]  r_force,     n_force;
    logic                     r_clip,      n_clip;
    logic [1:0]               r_fill,      n_fill;
    logic signed [DATA_W-1:0] r_integ,     n_integ;
    logic signed [DATA_W-1:0] r_last,      n_last;
    logic signed [DATA_W-1:0] r_h1,        n_h1;
    logic signed [DATA_W-1:0] r_h2,        n_h2;

    // Working registers
    logic signed [ACC_W-1:0]  r_acc,  n_acc;
    logic signed [DATA_W-1:0] r_t,    n_t;
    logic signed [DATA_W-1:0] r_err,  n_err;
    logic signed [DATA_W:0]   r_diff, n_diff;
    logic                     r_mode, n_mode;
    logic signed [DATA_W-1:0] r_pos,  n_pos;
    logic signed [DATA_W-1:0] r_vel,  n_vel;
    logic signed [DATA_W-1:0] r_rd0,  n_rd0;
    logic signed [DATA_W-1:0] r_rd1,  n_rd1;

    logic signed [MUL_W-1:0]  op_a, op_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  prod_f, prod_32, prod_full, d2, acc_sum;
    logic                     accept;

    pidsf_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    pidsf_mul u_mul (
        .i_clk  (i_clk),
        .i_op_a (op_a),
        .i_op_b (op_b),
        .o_prod (prod)
    );

    assign accept = i_item.valid && i_item.ready;

    assign i_item.ready            = (r_state == S_IDLE);
    assign o_result.valid          = r_out_valid;
    assign o_result.actuator_force = r_force;
    assign o_result.force_clipped  = r_clip;

    // Product taps: arithmetic shifts round toward minus infinity
    assign prod_f    = ACC_W'(prod >>> FRAC_BITS);
    assign prod_32   = ACC_W'(prod >>> 32);
    assign prod_full = ACC_W'(prod);
    assign d2        = ACC_W'(r_vel) - (ACC_W'(r_h1) <<< 1) + ACC_W'(r_h2);

    // Multiplier operand select
    always_comb begin
        op_a = '0;
        op_b = '0;
        case (r_state)
            S_P_W0: begin
                op_a = MUL_W'(cfg.dist_weight_0);
                op_b = MUL_W'(r_rd0);
            end
            S_P_W1: begin
                op_a = MUL_W'(cfg.dist_weight_1);
                op_b = MUL_W'(r_rd1);
            end
            S_J_M1, S_J_M2: begin
                op_a = MUL_W'(r_t);
                op_b = $signed({2'b00, cfg.inv_step_time});
            end
            S_J_A0: begin
                op_a = MUL_W'(r_t);
                op_b = ALPHA_Q;
            end
            S_J_A1: begin
                op_a = MUL_W'(r_last);
                op_b = ONE_M_ALPHA;
            end
            S_C_INT: begin
                op_a = MUL_W'(r_err);
                op_b = $signed({1'b0, cfg.step_time});
            end
            S_C_DER: begin
                op_a = r_diff;
                op_b = $signed({2'b00, cfg.inv_step_time});
            end
            S_C_GP: begin
                op_a = MUL_W'(cfg.gain_prop);
                op_b = MUL_W'(r_err);
            end
            S_C_GI: begin
                op_a = MUL_W'(cfg.gain_integ);
                op_b = MUL_W'(r_integ);
            end
            S_C_GD: begin
                op_a = MUL_W'(cfg.gain_deriv);
                op_b = MUL_W'(r_t);
            end
            S_C_VEL: begin
                op_a = MUL_W'(r_vel);
                op_b = VEL_GAIN_NEG;
            end
            default: ;
        endcase
    end

    // Sequencer next state and datapath
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_force     = r_force;
        n_clip      = r_clip;
        n_fill      = r_fill;
        n_integ     = r_integ;
        n_last      = r_last;
        n_h1        = r_h1;
        n_h2        = r_h2;
        n_acc       = r_acc;
        n_t         = r_t;
        n_err       = r_err;
        n_diff      = r_diff;
        n_mode      = r_mode;
        n_pos       = r_pos;
        n_vel       = r_vel;
        n_rd0       = r_rd0;
        n_rd1       = r_rd1;
        acc_sum     = r_acc + prod_f;

        // Drop the result once the receiver takes it
        if (o_result.valid && o_result.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_pos   = i_item.body_position;
                    n_vel   = i_item.body_velocity;
                    n_rd0   = i_item.road_input_0;
                    n_rd1   = i_item.road_input_1;
                    n_mode  = cfg.law_mode;
                    n_state = cfg.law_mode ? S_J_D2 : S_P_W0;
                end
            end
            // Position mode: error = position + weighted disturbances
            S_P_W0: begin
                n_acc   = ACC_W'(r_pos);
                n_state = S_P_W1;
            end
            S_P_W1: begin
                n_acc   = acc_sum;
                n_state = S_P_SUM;
            end
            S_P_SUM: begin
                n_err   = DIST_USE_1 ? sat32(acc_sum) : sat32(r_acc);
                n_state = S_C_INT;
            end
            // Jerk mode: second difference, scaled twice, then low-pass; zero while history fills
            S_J_D2: begin
                if (r_fill == 2'd2) begin
                    n_t     = sat32(d2);
                    n_state = S_J_M1;
                end else begin
                    n_fill  = r_fill + 2'd1;
                    n_t     = '0;
                    n_state = S_J_A0;
                end
            end
            S_J_M1: n_state = S_J_S1;
            S_J_S1: begin
                n_t     = sat32(prod_f);
                n_state = S_J_M2;
            end
            S_J_M2: n_state = S_J_S2;
            S_J_S2: begin
                n_t     = sat32(prod_f);
                n_state = S_J_A0;
            end
            S_J_A0: n_state = S_J_A1;
            S_J_A1: begin
                n_acc   = prod_full;
                n_state = S_J_ERR;
            end
            S_J_ERR: begin
                n_err   = sat32((r_acc + prod_full) >>> FRAC_BITS);
                n_h2    = r_h1;
                n_h1    = r_vel;
                n_state = S_C_INT;
            end
            // Common tail: integral, derivative, gain sum (plus velocity damping in jerk mode), clip
            S_C_INT: begin
                n_diff  = (DATA_W + 1)'(r_err) - (DATA_W + 1)'(r_last);
                n_state = S_C_DER;
            end
            S_C_DER: begin
                n_integ = sat32(ACC_W'(r_integ) + prod_32);
                n_state = S_C_GP;
            end
            S_C_GP: begin
                n_t     = sat32(prod_f);
                n_last  = r_err;
                n_state = S_C_GI;
            end
            S_C_GI: begin
                n_acc   = prod_f;
                n_state = S_C_GD;
            end
            S_C_GD: begin
                n_acc   = acc_sum;
                n_state = S_C_VEL;
            end
            S_C_VEL: begin
                n_acc   = acc_sum;
                n_state = S_C_SUM;
            end
            S_C_SUM: begin
                if (r_mode) begin
                    n_acc = r_acc + prod_full;
                end
                n_state = S_C_CLIP;
            end
            S_C_CLIP: begin
                // Hold here while an earlier result still waits
                if (!r_out_valid || o_result.ready) begin
                    n_out_valid = 1'b1;
                    if (r_acc > FORCE_LIMIT) begin
                        n_force = LIM_OUT;
                        n_clip  = 1'b1;
                    end else if (r_acc < -FORCE_LIMIT) begin
                        n_force = -LIM_OUT;
                        n_clip  = 1'b1;
                    end else begin
                        n_force = OUT_W'(r_acc);
                        n_clip  = 1'b0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_force     <= '0;
            r_clip      <= 1'b0;
            r_fill      <= '0;
            r_integ     <= '0;
            r_last      <= '0;
            r_h1        <= '0;
            r_h2        <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_force     <= n_force;
            r_clip      <= n_clip;
            r_fill      <= n_fill;
            r_integ     <= n_integ;
            r_last      <= n_last;
            r_h1        <= n_h1;
            r_h2        <= n_h2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc  <= n_acc;
        r_t    <= n_t;
        r_err  <= n_err;
        r_diff <= n_diff;
        r_mode <= n_mode;
        r_pos  <= n_pos;
        r_vel  <= n_vel;
        r_rd0  <= n_rd0;
        r_rd1  <= n_rd1;
    end

`ifndef SYNTHESIS
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill != 2'd3)
        else $error("history count past two");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != S_IDLE))
        else $error("sequencer idle right after accepting an item");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_C_CLIP && n_state == S_IDLE) |=> r_out_valid)
        else $error("finished item not presented");

    a_clip_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_clip) |-> (r_force == LIM_OUT || r_force == -LIM_OUT))
        else $error("clipped force not at a limit");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_result.ready) |-> (n_state != S_IDLE || r_state == S_IDLE))
        else $error("result overwritten while stalled");
`endif

endmodule

FILE: rtl/pidsf_cfg.sv
module pidsf_cfg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    pidsf_cfg_if.sink        i_cfg,
    output pidsf_pkg::t_cfg  o_cfg
);
    import pidsf_pkg::*;

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Take a write on every handshake; drop unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.law_mode      <= 1'b0;
            r_cfg.gain_prop     <= '0;
            r_cfg.gain_integ    <= '0;
            r_cfg.gain_deriv    <= '0;
            r_cfg.step_time     <= STEP_TIME_RST;
            r_cfg.inv_step_time <= INV_STEP_TIME_RST;
            r_cfg.dist_weight_0 <= '0;
            r_cfg.dist_weight_1 <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                REG_LAW_MODE:      r_cfg.law_mode      <= i_cfg.data[0];
                REG_GAIN_PROP:     r_cfg.gain_prop     <= i_cfg.data;
                REG_GAIN_INTEG:    r_cfg.gain_integ    <= i_cfg.data;
                REG_GAIN_DERIV:    r_cfg.gain_deriv    <= i_cfg.data;
                REG_STEP_TIME:     r_cfg.step_time     <= i_cfg.data;
                REG_INV_STEP_TIME: r_cfg.inv_step_time <= i_cfg.data[DATA_W-2:0];
                REG_DIST_WEIGHT_0: r_cfg.dist_weight_0 <= i_cfg.data;
                REG_DIST_WEIGHT_1: r_cfg.dist_weight_1 <= i_cfg.data;
                default: ;
            endcase
        end
    end

endmodule

FILE: rtl/pidsf_mul.sv
module pidsf_mul (
    input  logic                                i_clk,
    input  logic signed [pidsf_pkg::MUL_W-1:0]  i_op_a,
    input  logic signed [pidsf_pkg::MUL_W-1:0]  i_op_b,
    output logic signed [pidsf_pkg::PROD_W-1:0] o_prod
);
    import pidsf_pkg::*;

    logic signed [PROD_W-1:0] r_prod;

    // Register every product; the sequencer picks it up in the next cycle
    always_ff @(posedge i_clk) begin
        r_prod <= i_op_a * i_op_b;
    end

    assign o_prod = r_prod;

endmodule

FILE: tb/sv/tb_pidsf_checker.sv
`timescale 1ns / 100ps

module tb_pidsf_checker (
    input  logic     i_clk,
    input  logic     i_rst_n,
    pidsf_item_if    i_item,
    pidsf_result_if  i_result,
    pidsf_cfg_if     i_cfg,
    output int       o_fail_count,
    output int       o_pending
);
    import pidsf_pkg::*;

    localparam longint ONE_Q       = 64'sd1 <<< FRAC_BITS;
    localparam longint LPF_ALPHA   = (ONE_Q + 64'sd50) / 64'sd100;
    localparam longint FORCE_MAX   = 64'sd1000 <<< FRAC_BITS;
    localparam longint VEL_DAMPING = 64'sd200;
    localparam longint S32_HI      = 64'sd2147483647;
    localparam longint S32_LO      = -64'sd2147483648;

    typedef struct packed {
        logic signed [OUT_W-1:0] force_val;
        logic                    clipped;
    } t_force_sample;

    t_force_sample expected_forces[$];

    // Register mirror
    logic   jerk_mode;
    longint kp, ki, kd, period, inv_period, road_w0, road_w1;

    // Controller state mirror
    longint integ, prev_err, vel_h1, vel_h2;
    int unsigned hist_cnt;

    function automatic longint clamp32(input longint x);
        if (x > S32_HI) begin
            return S32_HI;
        end
        if (x < S32_LO) begin
            return S32_LO;
        end
        return x;
    endfunction

    function automatic longint times_rate(input longint x);
        return clamp32((x * inv_period) >>> FRAC_BITS);
    endfunction

    // Advance the controller by one sample and return the force it gives
    function automatic t_force_sample next_force(input longint pos, input longint vel,
                                                 input longint r0, input longint r1);
        t_force_sample res;
        longint err, jerk, deriv, force_acc;
        if (!jerk_mode) begin
            force_acc = pos + ((road_w0 * r0) >>> FRAC_BITS);
            if (DIST_COUNT >= 2) begin
                force_acc += (road_w1 * r1) >>> FRAC_BITS;
            end
            err = clamp32(force_acc);
        end else begin
            jerk = 0;
            if (hist_cnt >= 2) begin
                jerk = times_rate(times_rate(clamp32(vel - 2 * vel_h1 + vel_h2)));
            end else begin
                hist_cnt++;
            end
            err = clamp32((jerk * LPF_ALPHA + prev_err * (ONE_Q - LPF_ALPHA)) >>> FRAC_BITS);
            vel_h2 = vel_h1;
            vel_h1 = vel;
        end
        integ    = clamp32(integ + ((err * period) >>> 32));
        deriv    = times_rate(err - prev_err);
        prev_err = err;

        force_acc = ((kp * err) >>> FRAC_BITS) + ((ki * integ) >>> FRAC_BITS)
                  + ((kd * deriv) >>> FRAC_BITS);
        if (jerk_mode) begin
            force_acc -= VEL_DAMPING * vel;
        end
        res.clipped = 1'b0;
        if (force_acc > FORCE_MAX) begin
            force_acc   = FORCE_MAX;
            res.clipped = 1'b1;
        end else if (force_acc < -FORCE_MAX) begin
            force_acc   = -FORCE_MAX;
            res.clipped = 1'b1;
        end
        res.force_val = force_acc[OUT_W-1:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_force_sample want;
        if (!i_rst_n) begin
            jerk_mode    = 1'b0;
            kp           = 0;
            ki           = 0;
            kd           = 0;
            period       = STEP_TIME_RST;
            inv_period   = INV_STEP_TIME_RST;
            road_w0      = 0;
            road_w1      = 0;
            integ        = 0;
            prev_err     = 0;
            vel_h1       = 0;
            vel_h2       = 0;
            hist_cnt     = 0;
            o_fail_count = 0;
            expected_forces.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_LAW_MODE:      jerk_mode  = i_cfg.data[0];
                    REG_GAIN_PROP:     kp         = $signed(i_cfg.data);
                    REG_GAIN_INTEG:    ki         = $signed(i_cfg.data);
                    REG_GAIN_DERIV:    kd         = $signed(i_cfg.data);
                    REG_STEP_TIME:     period     = i_cfg.data;
                    REG_INV_STEP_TIME: inv_period = i_cfg.data[DATA_W-2:0];
                    REG_DIST_WEIGHT_0: road_w0    = $signed(i_cfg.data);
                    REG_DIST_WEIGHT_1: road_w1    = $signed(i_cfg.data);
                    default: ;
                endcase
            end
            if (i_result.valid && i_result.ready) begin
                if (expected_forces.size() == 0) begin
                    $display("%0t: unexpected force, actual %0d clipped %0b",
                             $time, i_result.actuator_force, i_result.force_clipped);
                    o_fail_count++;
                end else begin
                    want = expected_forces.pop_front();
                    if (i_result.actuator_force !== want.force_val) begin
                        $display("%0t: actuator_force expected %0d actual %0d",
                                 $time, want.force_val, i_result.actuator_force);
                        o_fail_count++;
                    end
                    if (i_result.force_clipped !== want.clipped) begin
                        $display("%0t: force_clipped expected %0b actual %0b",
                                 $time, want.clipped, i_result.force_clipped);
                        o_fail_count++;
                    end
                end
            end
            if (i_item.valid && i_item.ready) begin
                expected_forces.push_back(next_force(i_item.body_position,
                    i_item.body_velocity, i_item.road_input_0, i_item.road_input_1));
            end
        end
        o_pending = expected_forces.size();
    end

endmodule

FILE: tb/sv/tb_pid_suspension_force.sv
`timescale 1ns / 100ps

module tb_pid_suspension_force;
    import pidsf_pkg::*;

    localparam logic signed [DATA_W-1:0] S32_MAX     = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] S32_MIN     = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] Q_ONE       = 32'sh0001_0000;
    localparam logic signed [DATA_W-1:0] FORCE_BOUND = 32'sd65536000;
    // Index outside the register map: the block must drop the write
    localparam logic [CFG_IDX_W-1:0]     CFG_IDX_SPARE = 4'd12;
    localparam int PHASE_COUNT      = 8;
    localparam int PHASE_ITEMS      = 142;
    localparam int LONG_HOLD_CYCLES = 400;

    logic i_clk;
    logic i_rst_n;

    pidsf_item_if   item_ch();
    pidsf_result_if result_ch();
    pidsf_cfg_if    cfg_ch();

    int fail_count;
    int pending;

    // Idle and stall odds out of 100, set at the start of each phase
    int unsigned src_idle_pct  = 0;
    int unsigned sink_stall_pct = 0;
    // Long receiver hold-offs asked for by the stimulus, served by the sink
    int unsigned hold_requests = 0;
    int unsigned hold_served   = 0;

    pid_suspension_force u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch),
        .i_cfg    (cfg_ch)
    );

    tb_pidsf_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (item_ch),
        .i_result     (result_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Give up long after the slowest correct run would have ended
    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Force receiver: random stalls, plus long hold-offs on request so the
    // output register and the sequencer both fill and the block stops taking items
    initial begin
        int unsigned hold_left;
        hold_left = 0;
        result_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_requests != hold_served) begin
                hold_served++;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end else begin
                result_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
            end
        end
    end

    // Offer one sample; drop valid for random gaps, hold it until accepted
    task automatic send_sample(input logic [DATA_W-1:0] pos, input logic [DATA_W-1:0] vel,
                               input logic [DATA_W-1:0] r0, input logic [DATA_W-1:0] r1);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            item_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        item_ch.valid         <= 1'b1;
        item_ch.body_position <= pos;
        item_ch.body_velocity <= vel;
        item_ch.road_input_0  <= r0;
        item_ch.road_input_1  <= r1;
        do @(posedge i_clk); while (!item_ch.ready);
    endtask

    // Drop valid and hold until every expected force has come back
    task automatic drain;
        @(negedge i_clk);
        item_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Mostly signed values within +-2^span_bits, with extremes and full-range noise
    function automatic logic [DATA_W-1:0] pick_value(input int unsigned span_bits);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
            case ($urandom_range(0, 4))
                0:       return S32_MAX;
                1:       return S32_MIN;
                2:       return '0;
                3:       return '1;
                default: return 32'd1;
            endcase
        end
        if (roll < 30) begin
            return $urandom;
        end
        return $urandom_range(0, (1 << (span_bits + 1)) - 1) - (1 << span_bits);
    endfunction

    function automatic logic [DATA_W-1:0] pick_period;
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return $urandom;
            default: return STEP_TIME_RST + $urandom_range(0, 1 << 22);
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_rate;
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return 32'h7FFF_FFFF;
            2:       return $urandom_range(0, 32'h7FFF_FFFF);
            default: return Q_ONE * $urandom_range(1, 2000);
        endcase
    endfunction

    // Set every register for the next random phase
    task automatic load_random_setup(input logic jerk_law);
        write_reg(REG_LAW_MODE, {31'd0, jerk_law});
        write_reg(REG_GAIN_PROP, pick_value(17));
        write_reg(REG_GAIN_INTEG, pick_value(17));
        write_reg(REG_GAIN_DERIV, pick_value(12));
        write_reg(REG_STEP_TIME, pick_period());
        write_reg(REG_INV_STEP_TIME, pick_rate());
        write_reg(REG_DIST_WEIGHT_0, pick_value(17));
        write_reg(REG_DIST_WEIGHT_1, pick_value(17));
        if ($urandom_range(0, 1) == 1) begin
            write_reg(CFG_IDX_SPARE, $urandom);
        end
    endtask

    initial begin
        logic [DATA_W-1:0] vel;
        logic              jerk_law;

        // Drive every input to a known value before the first edge
        i_rst_n               = 1'b0;
        item_ch.valid         = 1'b0;
        item_ch.body_position = '0;
        item_ch.body_velocity = '0;
        item_ch.road_input_0  = '0;
        item_ch.road_input_1  = '0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.index          = '0;
        cfg_ch.data           = '0;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset defaults: zero gains give zero force whatever the sample
        send_sample(S32_MAX, S32_MAX, S32_MAX, S32_MAX);
        send_sample(S32_MIN, S32_MIN, S32_MIN, S32_MIN);
        drain();

        // Pure proportional unity gain: force equals the position, so probe
        // the clip bounds exactly, just inside and just outside
        write_reg(REG_GAIN_PROP, Q_ONE);
        write_reg(REG_GAIN_INTEG, '0);
        write_reg(REG_GAIN_DERIV, '0);
        send_sample(FORCE_BOUND, '0, '0, '0);
        send_sample(FORCE_BOUND + 1, '0, '0, '0);
        send_sample(-FORCE_BOUND, '0, '0, '0);
        send_sample(-FORCE_BOUND - 1, '0, '0, '0);
        send_sample('0, '0, '0, '0);
        drain();

        // Extreme weights, period and rate; saturate the error both ways
        write_reg(REG_GAIN_PROP, 32'sh0002_0000);
        write_reg(REG_GAIN_INTEG, Q_ONE);
        write_reg(REG_GAIN_DERIV, 32'sh0000_0080);
        write_reg(REG_STEP_TIME, '1);
        write_reg(REG_INV_STEP_TIME, 32'h7FFF_FFFF);
        write_reg(REG_DIST_WEIGHT_0, S32_MAX);
        write_reg(REG_DIST_WEIGHT_1, S32_MIN);
        write_reg(CFG_IDX_SPARE, '1);
        send_sample(S32_MAX, '0, S32_MAX, S32_MIN);
        send_sample(S32_MIN, '0, S32_MIN, S32_MAX);
        send_sample(S32_MAX, '0, S32_MIN, S32_MAX);
        send_sample(Q_ONE, '0, '0, '0);
        drain();

        // Zero period freezes the integral, zero rate kills the derivative
        write_reg(REG_STEP_TIME, '0);
        write_reg(REG_INV_STEP_TIME, '0);
        send_sample(32'sh0010_0000, '0, '0, '0);
        send_sample(-32'sh0020_0000, '0, '0, '0);
        drain();

        // Jerk law: two samples to fill the history, then velocity steps
        // large enough to saturate the scaled second difference
        write_reg(REG_LAW_MODE, 32'd1);
        write_reg(REG_STEP_TIME, STEP_TIME_RST);
        write_reg(REG_INV_STEP_TIME, INV_STEP_TIME_RST);
        write_reg(REG_GAIN_PROP, Q_ONE);
        write_reg(REG_GAIN_INTEG, 32'sh0000_0100);
        write_reg(REG_GAIN_DERIV, 32'sh0000_0010);
        send_sample('0, '0, '0, '0);
        send_sample('0, Q_ONE, '0, '0);
        send_sample('0, S32_MAX, '0, '0);
        send_sample('0, S32_MIN, '0, '0);
        drain();

        // Back to position law; the state carries over
        write_reg(REG_LAW_MODE, 32'd0);
        send_sample(32'sh0000_8000, '0, Q_ONE, -Q_ONE);
        send_sample(-32'sh0000_8000, '0, '0, '0);
        drain();

        // Random phases: idling pattern changes every two phases, the law
        // alternates, and both laws see every idling pattern
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            jerk_law = phase[0];
            case (phase / 2)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 68; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 68; end
                default: begin src_idle_pct = 29; sink_stall_pct = 29; end
            endcase
            load_random_setup(jerk_law);
            // Back-pressure test: hold the receiver off while items keep coming
            if (phase == 0 || phase == 5) begin
                hold_requests++;
            end
            vel = '0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (jerk_law) begin
                    // Smooth velocity track so the filtered jerk stays meaningful,
                    // with an occasional jump
                    if ($urandom_range(0, 99) < 85) begin
                        vel = vel + $urandom_range(0, 511) - 256;
                    end else begin
                        vel = pick_value(14);
                    end
                    send_sample(pick_value(18), vel, pick_value(16), pick_value(16));
                end else begin
                    send_sample(pick_value(18), pick_value(18), pick_value(16),
                                pick_value(16));
                end
            end
            drain();
        end

        // Let any stray force show up before the verdict
        repeat (40) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
